// File: sv/lfr_pkg.sv
package lfr_pkg;

  localparam int FLEN_W = 12;

  // input modes
  localparam logic [1:0] MODE_TX   = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_POLL = 2'd2;

  // result status codes
  localparam logic [2:0] ST_TAKEN   = 3'd0;
  localparam logic [2:0] ST_COMMIT  = 3'd1;
  localparam logic [2:0] ST_REJECT  = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_DELIVER = 3'd4;

  // register indexes (paddr[2])
  localparam logic REG_FRAME_SIZE = 1'b0;
  localparam logic REG_RING_DEPTH = 1'b1;

  localparam logic [11:0] FRAME_SIZE_RST = 12'd2048;
  localparam logic [3:0]  RING_DEPTH_RST = 4'd8;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        out_byte;
    logic              end_of_frame;
    logic [FLEN_W-1:0] frame_length;
  } out_item_t;

  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic finish;  // delivering read completes this cycle
  } ctrl_cmd_t;

  typedef struct packed {
    logic deliver; // presented item is a read that will deliver a byte
  } dp_status_t;

endpackage

// File: sv/lfr_dp.sv
module lfr_dp #(
  parameter int MAX_SLOTS   = 8,
  parameter int MAX_FRAME   = 2048,
  parameter int POLL_FRAMES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lfr_pkg::ctrl_cmd_t cmd_i,
  output lfr_pkg::dp_status_t status_o,
  input  lfr_pkg::in_item_t  in_item_i,
  input  logic [11:0]        frame_size_i,
  input  logic [3:0]         ring_depth_i,
  input  logic               ring_clr_i,
  output lfr_pkg::out_item_t out_item_o
);
  import lfr_pkg::*;

  localparam int SW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int DW        = $clog2(MAX_SLOTS + 1);
  localparam int OW        = $clog2(MAX_FRAME + 1);
  localparam int RW        = $clog2(MAX_FRAME);
  localparam int BW        = $clog2(POLL_FRAMES + 1);
  localparam int MEM_DEPTH = MAX_SLOTS * MAX_FRAME;
  localparam int AW        = $clog2(MEM_DEPTH);

  logic [SW-1:0] head_q, head_d;
  logic [DW-1:0] held_q, held_d;
  logic [OW-1:0] wo_q, wo_d;
  logic          drop_q, drop_d;
  logic [RW-1:0] ro_q, ro_d;
  logic [BW-1:0] budget_q, budget_d;

  logic [2:0]        status_q, status_d;
  logic              eof_q, eof_d;
  logic [FLEN_W-1:0] flen_q, flen_d;

  logic [7:0]    frame_mem [MEM_DEPTH];
  logic [OW-1:0] len_mem [MAX_SLOTS];
  logic [7:0]    rd_byte_q;
  logic [OW-1:0] len_rd_q;

  logic [31:0]   fs_ext, rd_ext;
  logic [OW-1:0] eff_frame;
  logic [DW-1:0] eff_depth;
  logic          drop_now;
  logic [DW:0]   tail_sum;
  logic [SW-1:0] tail;
  logic [OW-1:0] wo_inc;
  logic [OW-1:0] ro_inc;
  logic          ro_done;
  logic [DW-1:0] head_inc;
  logic [SW-1:0] head_next;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          mem_wr, len_wr, mem_rd;
  logic          deliver;

  always_comb begin
    fs_ext = 32'(frame_size_i);
    rd_ext = 32'(ring_depth_i);
    if (fs_ext == 32'd0 || fs_ext > 32'(MAX_FRAME)) begin
      eff_frame = OW'(MAX_FRAME);
    end else begin
      eff_frame = OW'(fs_ext);
    end
    if (rd_ext == 32'd0 || rd_ext > 32'(MAX_SLOTS)) begin
      eff_depth = DW'(MAX_SLOTS);
    end else begin
      eff_depth = DW'(rd_ext);
    end
  end

  assign drop_now = drop_q || (held_q >= eff_depth) || (wo_q >= eff_frame);
  assign wo_inc   = wo_q + 1'b1;

  // head < depth and held < depth when writing, so one subtract wraps
  always_comb begin
    tail_sum = (DW+1)'(head_q) + (DW+1)'(held_q);
    if (tail_sum >= (DW+1)'(eff_depth)) begin
      tail_sum = tail_sum - (DW+1)'(eff_depth);
    end
    tail = SW'(tail_sum);
  end

  assign wr_addr = AW'(32'(tail) * 32'(MAX_FRAME) + 32'(wo_q));
  assign rd_addr = AW'(32'(head_q) * 32'(MAX_FRAME) + 32'(ro_q));

  assign ro_inc   = OW'(ro_q) + 1'b1;
  assign ro_done  = ro_inc >= len_rd_q;
  assign head_inc = DW'(head_q) + 1'b1;
  assign head_next = (head_inc >= eff_depth) ? '0 : SW'(head_inc);

  assign deliver = (in_item_i.mode == MODE_READ) && (held_q != '0) && (budget_q != '0);
  assign status_o.deliver = deliver;

  always_comb begin
    head_d   = head_q;
    held_d   = held_q;
    wo_d     = wo_q;
    drop_d   = drop_q;
    ro_d     = ro_q;
    budget_d = budget_q;
    status_d = status_q;
    eof_d    = eof_q;
    flen_d   = flen_q;
    mem_wr   = 1'b0;
    len_wr   = 1'b0;
    mem_rd   = 1'b0;
    if (ring_clr_i) begin
      head_d = '0;
      held_d = '0;
      wo_d   = '0;
      drop_d = 1'b0;
      ro_d   = '0;
    end else if (cmd_i.accept) begin
      unique case (in_item_i.mode)
        MODE_TX: begin
          status_d = ST_TAKEN;
          eof_d    = 1'b0;
          flen_d   = '0;
          if (!drop_now) begin
            mem_wr = 1'b1;
            wo_d   = wo_inc;
            if (in_item_i.last_byte) begin
              len_wr   = 1'b1;
              held_d   = held_q + 1'b1;
              status_d = ST_COMMIT;
              flen_d   = FLEN_W'(wo_inc);
            end
          end else if (in_item_i.last_byte) begin
            status_d = ST_REJECT;
          end
          if (in_item_i.last_byte) begin
            wo_d   = '0;
            drop_d = 1'b0;
          end else begin
            drop_d = drop_now;
          end
        end
        MODE_READ: begin
          if (deliver) begin
            mem_rd = 1'b1;
          end else begin
            status_d = ST_EMPTY;
            eof_d    = 1'b0;
            flen_d   = '0;
          end
        end
        MODE_POLL: begin
          budget_d = BW'(POLL_FRAMES);
          status_d = ST_TAKEN;
          eof_d    = 1'b0;
          flen_d   = '0;
        end
        default: begin
          status_d = ST_TAKEN;
          eof_d    = 1'b0;
          flen_d   = '0;
        end
      endcase
    end else if (cmd_i.finish) begin
      status_d = ST_DELIVER;
      eof_d    = ro_done;
      flen_d   = FLEN_W'(len_rd_q);
      if (ro_done) begin
        ro_d     = '0;
        head_d   = head_next;
        held_d   = held_q - 1'b1;
        budget_d = budget_q - 1'b1;
      end else begin
        ro_d = RW'(ro_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      held_q   <= '0;
      wo_q     <= '0;
      drop_q   <= 1'b0;
      ro_q     <= '0;
      budget_q <= '0;
    end else begin
      head_q   <= head_d;
      held_q   <= held_d;
      wo_q     <= wo_d;
      drop_q   <= drop_d;
      ro_q     <= ro_d;
      budget_q <= budget_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    eof_q    <= eof_d;
    flen_q   <= flen_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      frame_mem[wr_addr] <= in_item_i.data_byte;
    end
    if (mem_rd) begin
      rd_byte_q <= frame_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_wr) begin
      len_mem[tail] <= wo_inc;
    end
    if (mem_rd) begin
      len_rd_q <= len_mem[head_q];
    end
  end

  always_comb begin
    out_item_o.status       = status_q;
    out_item_o.out_byte     = (status_q == ST_DELIVER) ? rd_byte_q : 8'd0;
    out_item_o.end_of_frame = eof_q;
    out_item_o.frame_length = flen_q;
  end

  a_held_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= eff_depth)
    else $error("frame count exceeds ring depth");

  a_head_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DW'(head_q) < eff_depth)
    else $error("head slot outside ring");

endmodule

// File: sv/lfr_ctrl.sv
module lfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  lfr_pkg::dp_status_t dp_status_i,
  output lfr_pkg::ctrl_cmd_t  cmd_o
);
  import lfr_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_FETCH = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // output slot is free if empty or its result transfers this cycle
  assign out_free     = !out_valid_q || !out_stall_i;
  assign in_stall_o   = !((state_q == S_IDLE) && out_free);
  assign cmd_o.accept = in_valid_i && !in_stall_o;
  assign cmd_o.finish = (state_q == S_FETCH);
  assign out_valid_o  = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.accept) begin
          if (dp_status_i.deliver) begin
            state_d = S_FETCH;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_FETCH: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_fetch_after_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && dp_status_i.deliver |=> (state_q == S_FETCH) && !out_valid_o)
    else $error("delivering read did not enter fetch with a free output");

  a_fetch_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |=> out_valid_o && (state_q == S_IDLE))
    else $error("fetch did not present its result");

  a_no_accept_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !cmd_o.accept)
    else $error("item taken while result is stalled");

endmodule

// File: sv/loopback_frame_ring_top.sv
// Loopback ring of whole frames with a per-slot length table.
// Input channel (in_valid_i / in_stall_o) carries one item per transfer:
// transmit byte, read one byte, or begin poll. Output channel
// (out_valid_o / out_stall_i) returns exactly one result per item, in order.
// Transmit, poll and non-delivering reads: the result is registered at the
// edge that takes the item and shows the next cycle; with the output drained
// a new item is taken every cycle.
// A read that delivers a byte first fetches the byte from the frame RAM and
// the length from the length RAM (both with registered read ports) in the
// fetch state, then the result is registered. No new item is taken during
// the fetch, and the output register is empty while it runs.
// While a result is held by out_stall_i, in_stall_o stays high; the result is
// taken in the same cycle as the next item, so a non-delivering item refills
// the output register with no bubble.
// Reset empties the ring and clears the poll budget; frame_size resets to 2048
// and ring_depth to 8. Frame and length RAMs are not cleared and need no pass.
// Write ring_depth or frame_size over the APB port only while idle; a
// ring_depth write empties the ring.
module loopback_frame_ring_top #(
  parameter int MAX_SLOTS   = 8,
  parameter int MAX_FRAME   = 2048,
  parameter int POLL_FRAMES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lfr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lfr_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lfr_pkg::*;

  logic [11:0] frame_size_q;
  logic [3:0]  ring_depth_q;
  logic        cfg_wr;
  logic        ring_clr;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign ring_clr = cfg_wr && (paddr[2] == REG_RING_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_size_q <= FRAME_SIZE_RST;
      ring_depth_q <= RING_DEPTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FRAME_SIZE: frame_size_q <= pwdata[11:0];
        REG_RING_DEPTH: ring_depth_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_SIZE: prdata = 32'(frame_size_q);
      REG_RING_DEPTH: prdata = 32'(ring_depth_q);
      default:        prdata = '0;
    endcase
  end

  lfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  lfr_dp #(
    .MAX_SLOTS   (MAX_SLOTS),
    .MAX_FRAME   (MAX_FRAME),
    .POLL_FRAMES (POLL_FRAMES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .in_item_i    (in_item_i),
    .frame_size_i (frame_size_q),
    .ring_depth_i (ring_depth_q),
    .ring_clr_i   (ring_clr),
    .out_item_o   (out_item_o)
  );

endmodule

// File: bench/loopback_frame_ring_top_test.sv
`timescale 1ns / 1ps

module loopback_frame_ring_top_test;
  import lfr_pkg::*;

  localparam int unsigned SLOT_COUNT    = 8;
  localparam int unsigned FRAME_MAX     = 2048;
  localparam int unsigned POLL_FRAMES   = 16;
  localparam int unsigned LONG_FRAME    = 256;
  localparam logic [1:0]  MODE_IGNORED  = 2'd3;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  // Frame ring predictor plus the queue of replies it expects, in order.
  class ring_checker;
    bit [7:0]    slot_bytes [SLOT_COUNT*FRAME_MAX];
    int unsigned slot_len [SLOT_COUNT];
    int unsigned head, held, wr_off, rd_off, budget;
    bit          dropping;
    int unsigned frame_size_reg, ring_depth_reg;
    out_item_t   pending_replies [$];
    int unsigned mismatches;

    function new();
      frame_size_reg = FRAME_SIZE_RST;
      ring_depth_reg = RING_DEPTH_RST;
      budget = 0;
      mismatches = 0;
      empty_ring();
    endfunction

    function void empty_ring();
      head = 0;
      held = 0;
      wr_off = 0;
      rd_off = 0;
      dropping = 1'b0;
    endfunction

    function int unsigned frame_limit();
      if (frame_size_reg == 0 || frame_size_reg > FRAME_MAX) return FRAME_MAX;
      return frame_size_reg;
    endfunction

    function int unsigned depth_limit();
      if (ring_depth_reg == 0 || ring_depth_reg > SLOT_COUNT) return SLOT_COUNT;
      return ring_depth_reg;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == REG_FRAME_SIZE) begin
        frame_size_reg = value & 32'hfff;
      end else begin
        ring_depth_reg = value & 32'hf;
        empty_ring();
      end
    endfunction

    function int unsigned pending();
      return pending_replies.size();
    endfunction

    function void take_item(in_item_t item);
      out_item_t   reply;
      int unsigned depth, tail, slot;
      reply = '0;
      reply.status = ST_TAKEN;
      depth = depth_limit();
      case (item.mode)
        MODE_TX: begin
          if (held >= depth || wr_off >= frame_limit()) dropping = 1'b1;
          if (!dropping) begin
            tail = (head + held) % depth;
            slot_bytes[tail*FRAME_MAX + wr_off] = item.data_byte;
            wr_off++;
            if (item.last_byte) begin
              slot_len[tail] = wr_off;
              held++;
              reply.status = ST_COMMIT;
              reply.frame_length = FLEN_W'(wr_off);
            end
          end else if (item.last_byte) begin
            reply.status = ST_REJECT;
          end
          if (item.last_byte) begin
            wr_off = 0;
            dropping = 1'b0;
          end
        end
        MODE_READ: begin
          if (held == 0 || budget == 0) begin
            reply.status = ST_EMPTY;
          end else begin
            slot = head % depth;
            reply.status = ST_DELIVER;
            reply.out_byte = slot_bytes[slot*FRAME_MAX + rd_off];
            reply.frame_length = FLEN_W'(slot_len[slot]);
            rd_off++;
            // free the head slot after its last byte
            if (rd_off >= slot_len[slot]) begin
              reply.end_of_frame = 1'b1;
              rd_off = 0;
              head = (slot + 1) % depth;
              held--;
              budget--;
            end
          end
        end
        MODE_POLL: budget = POLL_FRAMES;
        default: ;
      endcase
      pending_replies.push_back(reply);
    endfunction

    function void compare_field(string field, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d byte %0d",
                 $time, got.status, got.out_byte);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("end_of_frame", want.end_of_frame, got.end_of_frame);
      compare_field("frame_length", want.frame_length, got.frame_length);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ring_checker ring;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned cycle_count = 0;

  loopback_frame_ring_top u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) ring.check_reply(out_item_o);
      if (in_valid_i && !in_stall_o) ring.take_item(in_item_i);
    end
  end

  // Result-side stall: random runs, a quiet mode, and one long hold on request.
  initial begin : rx_stall_gen
    int unsigned pick, run;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (rx_quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        out_stall_i <= (pick >= 65);
        run = (pick >= 96) ? $urandom_range(10, 50) : $urandom_range(0, 3);
        repeat (run) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [7:0] data, input logic last);
    in_item_t    item;
    int unsigned pick, gap;
    item.mode = mode;
    item.data_byte = data;
    item.last_byte = last;
    in_valid_i <= 1'b1;
    in_item_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pick = $urandom_range(0, 99);
    if (tx_quiet || pick < 60) gap = 0;
    else if (pick < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_frame(input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      // occasionally break into the frame with a read
      if ($urandom_range(0, 99) < 3) send_item(MODE_READ, 8'h00, 1'b0);
      send_item(MODE_TX, 8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (ring.pending() != 0);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // pready is always high: the transfer completes at this edge
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] value);
    logic [31:0] readback, want;
    logic [2:0]  addr;
    addr = {idx, 2'b00};
    want = (idx == REG_FRAME_SIZE) ? (value & 32'hfff) : (value & 32'hf);
    apb_access(1'b1, addr, value, readback);
    ring.write_reg(idx, value);
    apb_access(1'b0, addr, 32'h0, readback);
    if (readback !== want) begin
      $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
               $time, idx, want, readback);
      ring.mismatches++;
    end
  endtask

  task automatic configure(input int unsigned frame_size, input int unsigned ring_depth);
    drain_results();
    write_register(REG_FRAME_SIZE, ($urandom() & ~32'hfff) | frame_size);
    write_register(REG_RING_DEPTH, ($urandom() & ~32'hf) | ring_depth);
  endtask

  task automatic run_traffic(input int unsigned count);
    int unsigned sent, pick, len, cap;
    logic [1:0]  mode;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        cap = ring.frame_limit() + 2;
        if (cap > 20) cap = 20;
        len = $urandom_range(1, cap);
        send_frame(len);
        sent += len;
      end else if (pick < 78) begin
        len = $urandom_range(1, 8);
        repeat (len) send_item(MODE_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent += len;
      end else if (pick < 86) begin
        send_item(MODE_POLL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent++;
      end else if (pick < 97) begin
        mode = 2'($urandom_range(0, 3));
        send_item(mode, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if (mode != MODE_IGNORED) sent++;
      end else begin
        drain_results();
      end
    end
  endtask

  task automatic directed_checks();
    send_item(MODE_READ, 8'h00, 1'b0);      // no budget, empty ring
    send_item(MODE_IGNORED, 8'hff, 1'b1);
    send_item(MODE_POLL, 8'h00, 1'b0);
    send_item(MODE_READ, 8'hff, 1'b1);      // budget armed, still empty
    send_item(MODE_TX, 8'hff, 1'b1);
    send_item(MODE_TX, 8'h00, 1'b0);
    send_item(MODE_TX, 8'ha5, 1'b0);
    send_item(MODE_TX, 8'h5a, 1'b1);
    repeat (5) send_item(MODE_READ, 8'h00, 1'b0);
    // shrink frame_size under a frame already longer than the new size
    send_item(MODE_TX, 8'h11, 1'b0);
    send_item(MODE_TX, 8'h22, 1'b0);
    drain_results();
    write_register(REG_FRAME_SIZE, 32'd1);
    send_item(MODE_TX, 8'h33, 1'b1);
    send_item(MODE_TX, 8'h44, 1'b1);
    // depth rewrite empties the ring but keeps the budget
    drain_results();
    write_register(REG_RING_DEPTH, 32'd1);
    send_item(MODE_READ, 8'h00, 1'b0);
    send_item(MODE_TX, 8'h77, 1'b1);
    send_item(MODE_READ, 8'h00, 1'b0);
    send_item(MODE_TX, 8'h88, 1'b1);
    send_item(MODE_TX, 8'h99, 1'b0);        // ring full from here on
    send_item(MODE_TX, 8'h66, 1'b1);
  endtask

  initial begin
    int unsigned phase;
    ring = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_checks();
    for (phase = 0; phase < 8; phase++) begin
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      case (phase)
        0: begin
          configure(2048, 8);
          hold_request = 1'b1;
          run_traffic(150);
        end
        1: begin
          configure(1, 1);
          run_traffic(100);
        end
        2: begin
          configure(4095, 15);
          run_traffic(150);
        end
        3: begin
          // one long frame, written and read back whole
          tx_quiet = 1'b1;
          rx_quiet = 1'b1;
          configure(0, 0);
          send_item(MODE_POLL, 8'h00, 1'b0);
          send_frame(LONG_FRAME);
          repeat (LONG_FRAME) send_item(MODE_READ, 8'h00, 1'b0);
          run_traffic(50);
        end
        4: begin
          configure(6, 3);
          run_traffic(150);
        end
        5: begin
          tx_quiet = 1'b1;
          rx_quiet = 1'b1;
          configure(2048, 8);
          run_traffic(120);
        end
        default: begin
          configure($urandom_range(1, 24), $urandom_range(1, 8));
          run_traffic(120);
        end
      endcase
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (ring.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
